FILE: rtl/swdk_pkg.sv
// Shared types, constants and the arctangent table for the swerve drive
// kinematics and odometry block. Used by the serial multiplier and the top level.
package swdk_pkg;

  localparam int NUM_WHEELS   = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_TABLE    = 24;
  localparam int N_STEPS      = (CORDIC_STEPS < MAX_TABLE) ? CORDIC_STEPS : MAX_TABLE;

  localparam int MCAND_W = 40;
  localparam int MPLR_W  = 32;
  localparam int PROD_W  = 72;

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] RAD_TO_BIN_C = 32'd42722830;

  localparam logic [1:0] CFG_X_OFFSET = 2'd0;
  localparam logic [1:0] CFG_Y_OFFSET = 2'd1;
  localparam logic [1:0] CFG_INV_RAD  = 2'd2;

  typedef struct packed {
    logic                      start;
    logic signed [MCAND_W-1:0] a;
    logic [MPLR_W-1:0]         b;
  } mul_req_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/swdk_mul.sv
// Bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier.
// Depends on swdk_pkg for the request type and widths.
module swdk_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swdk_pkg::mul_req_t                 req,
  output logic                               busy,
  output logic signed [swdk_pkg::PROD_W-1:0] prod
);

  logic signed [swdk_pkg::PROD_W-1:0] m_r;
  logic signed [swdk_pkg::PROD_W-1:0] acc_r;
  logic [swdk_pkg::MPLR_W-1:0]        b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (req.start) begin
      m_r   <= {{(swdk_pkg::PROD_W-swdk_pkg::MCAND_W){req.a[swdk_pkg::MCAND_W-1]}}, req.a};
      b_r   <= req.b;
      acc_r <= '0;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + m_r;
      end
      m_r <= m_r <<< 1;
      b_r <= b_r >> 1;
    end
  end

  assign busy = (b_r != '0);
  assign prod = acc_r;

endmodule

FILE: rtl/swerve_drive_kinematics_odometry_unit.sv
// Swerve drive inverse kinematics and odometry, top level.
// Depends on swdk_pkg and swdk_mul.
//
// Each request is one control tick and yields four results, one per wheel, handed
// out on consecutive cycles when the sink is ready. The work is up to five CORDIC
// passes on one shared shift-add stage and up to thirteen products on one bit-serial
// multiplier. The multiplier works through its multiplier operand one bit at a time,
// up to the highest set bit, so the cost of each product depends on its operands, and
// of the rate and pose products on the inverse radius and the period. A wheel with a
// zero velocity vector skips its CORDIC pass and its products. The input is not ready
// while a request is in work or its results are being delivered.
module swerve_drive_kinematics_odometry_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  input  logic [15:0]        in_period,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_wheel_index,
  output logic [19:0]        out_wheel_rate,
  output logic signed [15:0] out_steer_angle,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [15:0] out_heading,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WVEC, S_VEC, S_GAIN_V, S_RATE, S_HEAD, S_ROT_SETUP, S_ROT,
    S_GAIN_RX, S_GAIN_RY, S_PX, S_PY, S_OUT
  } state_t;

  state_t state_r;

  logic [63:0] xpack_r, ypack_r;
  logic [15:0] inv_rad_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [15:0] heading_r;

  logic signed [15:0] vx_r, vy_r, w_r;
  logic [15:0] dt_r;
  logic signed [35:0] x_r, y_r, rx_r, ry_r;
  logic signed [33:0] z_r;
  logic [4:0] iter_r;
  logic [1:0] wheel_r, oidx_r;
  logic [19:0] rate_r [swdk_pkg::NUM_WHEELS];
  logic [15:0] steer_r [swdk_pkg::NUM_WHEELS];

  swdk_pkg::mul_req_t mul_req_r;
  logic mul_busy;
  logic signed [swdk_pkg::PROD_W-1:0] prod;

  swdk_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req_r),
    .busy (mul_busy),
    .prod (prod)
  );

  logic mul_done;
  logic mul_start_nxt;
  logic signed [35:0] dx, dy, gain, wx, wy, x0, y0;
  logic signed [33:0] at;
  logic signed [15:0] xo, yo;
  logic signed [31:0] wyo, wxo;
  logic signed [32:0] wdt;
  logic signed [swdk_pkg::PROD_W-1:0] rsum, hsum, psum;
  logic [19:0] rate_val;
  logic [31:0] zs, ang;
  logic signed [43:0] disp;
  logic signed [44:0] sx, sy;
  logic signed [31:0] satx, saty;

  always_comb begin
    mul_done = !mul_req_r.start && !mul_busy;
    dx   = y_r >>> iter_r;
    dy   = x_r >>> iter_r;
    at   = {2'b00, swdk_pkg::atan_turn(iter_r)};
    gain = prod[65:30];
    xo   = xpack_r[{wheel_r, 4'b0000} +: 16];
    yo   = ypack_r[{wheel_r, 4'b0000} +: 16];
    wyo  = w_r * yo;
    wxo  = w_r * xo;
    wx   = {{8{vx_r[15]}}, vx_r, 12'h000} - {{4{wyo[31]}}, wyo};
    wy   = {{8{vy_r[15]}}, vy_r, 12'h000} + {{4{wxo[31]}}, wxo};
    wdt  = w_r * $signed({1'b0, dt_r});
    rsum = prod + (72'sd1 <<< 23);
    rate_val = (|rsum[71:44]) ? 20'hFFFFF : rsum[43:24];
    zs   = z_r[31:0] + 32'h0000_8000;
    hsum = prod + (72'sd1 <<< 39);
    psum = prod + (72'sd1 <<< 27);
    disp = psum[71:28];
    sx   = {{13{pos_x_r[31]}}, pos_x_r} + {disp[43], disp};
    sy   = {{13{pos_y_r[31]}}, pos_y_r} + {disp[43], disp};
    satx = (sx > 45'sd2147483647) ? 32'sh7FFFFFFF :
           (sx < -45'sd2147483648) ? 32'sh80000000 : sx[31:0];
    saty = (sy > 45'sd2147483647) ? 32'sh7FFFFFFF :
           (sy < -45'sd2147483648) ? 32'sh80000000 : sy[31:0];
    ang  = {heading_r, 16'h0000};
    x0   = {{4{vx_r[15]}}, vx_r, 16'h0000};
    y0   = {{4{vy_r[15]}}, vy_r, 16'h0000};
  end

  always_comb begin
    mul_start_nxt = 1'b0;
    unique case (state_r)
      S_WVEC:    mul_start_nxt = (wx == '0 && wy == '0) &&
                                 (wheel_r == 2'(swdk_pkg::NUM_WHEELS - 1));
      S_GAIN_V:  mul_start_nxt = (iter_r == 5'(swdk_pkg::N_STEPS)) || mul_done;
      S_RATE:    mul_start_nxt = mul_done && (wheel_r == 2'(swdk_pkg::NUM_WHEELS - 1));
      S_GAIN_RX: mul_start_nxt = (iter_r == 5'(swdk_pkg::N_STEPS)) || mul_done;
      S_GAIN_RY: mul_start_nxt = mul_done;
      S_PX:      mul_start_nxt = mul_done;
      default:   mul_start_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      xpack_r   <= '0;
      ypack_r   <= '0;
      inv_rad_r <= 16'd2519;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
      wheel_r   <= '0;
      oidx_r    <= '0;
      iter_r    <= '0;
      mul_req_r.start <= 1'b0;
    end else begin
      mul_req_r.start <= mul_start_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          swdk_pkg::CFG_X_OFFSET: xpack_r   <= cfg_data;
          swdk_pkg::CFG_Y_OFFSET: ypack_r   <= cfg_data;
          swdk_pkg::CFG_INV_RAD:  inv_rad_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            vx_r    <= in_vel_x;
            vy_r    <= in_vel_y;
            w_r     <= in_yaw_rate;
            dt_r    <= in_period;
            wheel_r <= '0;
            state_r <= S_WVEC;
          end
        end
        S_WVEC: begin
          iter_r <= '0;
          if (wx == '0 && wy == '0) begin
            rate_r[wheel_r]  <= '0;
            steer_r[wheel_r] <= '0;
            if (wheel_r == 2'(swdk_pkg::NUM_WHEELS - 1)) begin
              mul_req_r.a <= {{7{wdt[32]}}, wdt};
              mul_req_r.b <= swdk_pkg::RAD_TO_BIN_C;
              state_r     <= S_HEAD;
            end else begin
              wheel_r <= wheel_r + 2'd1;
            end
          end else begin
            if (wx[35]) begin
              x_r <= -wx;
              y_r <= -wy;
              z_r <= 34'sh0_8000_0000;
            end else begin
              x_r <= wx;
              y_r <= wy;
              z_r <= '0;
            end
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          if (!y_r[35]) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end
          iter_r <= iter_r + 5'd1;
          if (iter_r == 5'(swdk_pkg::N_STEPS - 1)) begin
            state_r <= S_GAIN_V;
          end
        end
        S_GAIN_V: begin
          if (iter_r == 5'(swdk_pkg::N_STEPS)) begin
            mul_req_r.a <= {{4{x_r[35]}}, x_r};
            mul_req_r.b <= swdk_pkg::INV_GAIN_Q30;
            iter_r      <= '0;
          end else if (mul_done) begin
            mul_req_r.a <= {{4{gain[35]}}, gain};
            mul_req_r.b <= {16'h0000, inv_rad_r};
            state_r     <= S_RATE;
          end
        end
        S_RATE: begin
          if (mul_done) begin
            rate_r[wheel_r]  <= rate_val;
            steer_r[wheel_r] <= zs[31:16];
            if (wheel_r == 2'(swdk_pkg::NUM_WHEELS - 1)) begin
              mul_req_r.a <= {{7{wdt[32]}}, wdt};
              mul_req_r.b <= swdk_pkg::RAD_TO_BIN_C;
              state_r     <= S_HEAD;
            end else begin
              wheel_r <= wheel_r + 2'd1;
              state_r <= S_WVEC;
            end
          end
        end
        S_HEAD: begin
          if (mul_done) begin
            heading_r <= heading_r + hsum[55:40];
            state_r   <= S_ROT_SETUP;
          end
        end
        S_ROT_SETUP: begin
          iter_r <= '0;
          if (ang > 32'h4000_0000 && ang < 32'hC000_0000) begin
            x_r <= -x0;
            y_r <= -y0;
            z_r <= {{2{~ang[31]}}, ~ang[31], ang[30:0]};
          end else begin
            x_r <= x0;
            y_r <= y0;
            z_r <= {{2{ang[31]}}, ang};
          end
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (!z_r[33]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          iter_r <= iter_r + 5'd1;
          if (iter_r == 5'(swdk_pkg::N_STEPS - 1)) begin
            state_r <= S_GAIN_RX;
          end
        end
        S_GAIN_RX: begin
          if (iter_r == 5'(swdk_pkg::N_STEPS)) begin
            mul_req_r.a <= {{4{x_r[35]}}, x_r};
            mul_req_r.b <= swdk_pkg::INV_GAIN_Q30;
            iter_r      <= '0;
          end else if (mul_done) begin
            rx_r        <= gain;
            mul_req_r.a <= {{4{y_r[35]}}, y_r};
            mul_req_r.b <= swdk_pkg::INV_GAIN_Q30;
            state_r     <= S_GAIN_RY;
          end
        end
        S_GAIN_RY: begin
          if (mul_done) begin
            ry_r        <= gain;
            mul_req_r.a <= {{4{rx_r[35]}}, rx_r};
            mul_req_r.b <= {16'h0000, dt_r};
            state_r     <= S_PX;
          end
        end
        S_PX: begin
          if (mul_done) begin
            pos_x_r     <= satx;
            mul_req_r.a <= {{4{ry_r[35]}}, ry_r};
            mul_req_r.b <= {16'h0000, dt_r};
            state_r     <= S_PY;
          end
        end
        S_PY: begin
          if (mul_done) begin
            pos_y_r <= saty;
            oidx_r  <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (oidx_r == 2'(swdk_pkg::NUM_WHEELS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              oidx_r <= oidx_r + 2'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = (state_r == S_OUT);
  assign out_wheel_index = oidx_r;
  assign out_wheel_rate  = rate_r[oidx_r];
  assign out_steer_angle = steer_r[oidx_r];
  assign out_pose_x      = pos_x_r;
  assign out_pose_y      = pos_y_r;
  assign out_heading     = heading_r;
  assign out_last        = (oidx_r == 2'(swdk_pkg::NUM_WHEELS - 1));

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input ready while results pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready) else $error("not idle after last");

endmodule
